[hw/rtl/rli_pkg.sv]
// shared constants, types and helpers for the ray line intersection pipeline
// no dependencies; imported by every module of the block
package rli_pkg;

    localparam int FRACTION_BITS  = 16;
    localparam int TANGENT_STAGES = 16;
    localparam int QUARTER_TURN   = 16384;
    localparam int ANGLE_SHIFT    = 16;

    localparam int COORD_W   = 32;
    localparam int HEAD_W    = 16;
    localparam int ATOL_W    = 11;
    localparam int STOL_W    = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;

    localparam int CORD_W = 34;
    localparam int ZW     = 34;
    localparam int DIV_W  = 68;
    localparam int QUO_W  = 32;
    localparam int IDX_W  = 5;
    localparam int BW     = 68;
    localparam int SLOPE_W = 32;
    localparam int PROD_W  = 64;

    localparam int LATENCY = TANGENT_STAGES + 2 * QUO_W + 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_TOL = 1'b0,
        REG_SLOPE_TOL = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [CORD_W-1:0] cx;
        logic signed [CORD_W-1:0] sy;
        logic signed [ZW-1:0]     z;
    } cord_t;

    typedef struct packed {
        logic [DIV_W-1:0] p;
        logic [DIV_W-1:0] d;
        logic [QUO_W-1:0] q;
    } div_t;

    // atan(2^-i), 2^32 per full turn
    function automatic logic signed [ZW-1:0] arc_of(input logic [IDX_W-1:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return signed'({{(ZW-32){1'b0}}, a});
    endfunction

    // arithmetic shift rounding toward zero
    function automatic logic signed [CORD_W-1:0] shift_tz(
        input logic signed [CORD_W-1:0] v,
        input logic [IDX_W-1:0]         sh
    );
        logic signed [CORD_W-1:0] m;
        m = v[CORD_W-1] ? -v : v;
        m = m >>> sh;
        return v[CORD_W-1] ? -m : m;
    endfunction

endpackage

[hw/rtl/rli_cordic_cell.sv]
// one cordic rotation step of the tangent chain
// depends on rli_pkg
module rli_cordic_cell (
    input  logic                     clk,
    input  logic [rli_pkg::IDX_W-1:0] stage,
    input  rli_pkg::cord_t           cell_in,
    output rli_pkg::cord_t           cell_out
);
    import rli_pkg::*;

    cord_t                    cell_reg;
    cord_t                    cell_next;
    logic signed [CORD_W-1:0] sy_sh;
    logic signed [CORD_W-1:0] cx_sh;
    logic signed [ZW-1:0]     arc;

    always_comb
    begin
        sy_sh = shift_tz(cell_in.sy, stage);
        cx_sh = shift_tz(cell_in.cx, stage);
        arc   = arc_of(stage);
        if (!cell_in.z[ZW-1])
        begin
            cell_next.cx = cell_in.cx - sy_sh;
            cell_next.sy = cell_in.sy + cx_sh;
            cell_next.z  = cell_in.z - arc;
        end
        else
        begin
            cell_next.cx = cell_in.cx + sy_sh;
            cell_next.sy = cell_in.sy - cx_sh;
            cell_next.z  = cell_in.z + arc;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

[hw/rtl/rli_div_cell.sv]
// one restoring division step, settles one quotient bit
// depends on rli_pkg
module rli_div_cell (
    input  logic                     clk,
    input  logic [rli_pkg::IDX_W-1:0] bit_idx,
    input  rli_pkg::div_t            cell_in,
    output rli_pkg::div_t            cell_out
);
    import rli_pkg::*;

    div_t             cell_reg;
    div_t             cell_next;
    logic [DIV_W-1:0] trial;

    always_comb
    begin
        trial     = cell_in.d << bit_idx;
        cell_next = cell_in;
        if (cell_in.p >= trial)
        begin
            cell_next.p          = cell_in.p - trial;
            cell_next.q[bit_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

[hw/rtl/ray_line_intersection.sv]
// line pair crossing point from start to done, one request per cycle
// the path runs through the cordic chain (16 cells) and two 32-cell divider chains in series
// results leave on done for one cycle; the receiver cannot stall, busy stays low
// reset clears the valid pipeline; angle_tolerance resets to 8, slope_tolerance to 1
// depends on rli_pkg, rli_cordic_cell, rli_div_cell
module ray_line_intersection (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [rli_pkg::COORD_W-1:0]    first_x,
    input  logic signed [rli_pkg::COORD_W-1:0]    first_y,
    input  logic signed [rli_pkg::HEAD_W-1:0]     first_heading,
    input  logic signed [rli_pkg::COORD_W-1:0]    second_x,
    input  logic signed [rli_pkg::COORD_W-1:0]    second_y,
    input  logic signed [rli_pkg::HEAD_W-1:0]     second_heading,
    input  logic                                  cfg_we,
    input  logic [rli_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rli_pkg::CFG_W-1:0]             cfg_data,
    output logic                                  done,
    output logic signed [rli_pkg::COORD_W-1:0]    cross_x,
    output logic signed [rli_pkg::COORD_W-1:0]    cross_y,
    output logic                                  no_crossing,
    output logic                                  clipped
);
    import rli_pkg::*;

    localparam logic signed [CORD_W-1:0] CORD_START = CORD_W'(64'd1 << 30);
    localparam logic [QUO_W-1:0]         SLOPE_CAP  = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic signed [BW-1:0]     SAT_HI     = {{(BW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [BW-1:0]     SAT_LO     = {{(BW-31){1'b1}}, {31{1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic                      bv;
        logic                      none;
    } side_t;

    typedef struct packed {
        side_t side;
        logic  a_cap;
        logic  a_neg;
        logic  b_cap;
        logic  b_neg;
    } slope_side_t;

    typedef struct packed {
        side_t                     side;
        logic signed [SLOPE_W-1:0] m1;
        logic signed [SLOPE_W-1:0] m2;
    } mstage_t;

    typedef struct packed {
        side_t                     side;
        logic signed [SLOPE_W-1:0] m1;
        logic signed [SLOPE_W-1:0] m2;
        logic signed [PROD_W-1:0]  p1;
        logic signed [PROD_W-1:0]  p2;
    } pstage_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic                      bv;
        logic                      none;
        logic signed [SLOPE_W-1:0] m1;
        logic signed [BW-1:0]      b1;
        logic signed [BW-1:0]      b2;
        logic signed [SLOPE_W:0]   den;
    } bstage_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic                      bv;
        logic                      none;
        logic                      neg;
        logic                      ovf;
        logic signed [SLOPE_W-1:0] m1;
        logic signed [BW-1:0]      b1;
    } xside_t;

    typedef struct packed {
        logic                      none;
        logic                      clip;
        logic signed [COORD_W-1:0] x;
        logic signed [SLOPE_W-1:0] m1;
        logic signed [BW-1:0]      b1;
    } qstage_t;

    typedef struct packed {
        logic                      none;
        logic                      clip;
        logic signed [COORD_W-1:0] x;
        logic signed [PROD_W-1:0]  p;
        logic signed [BW-1:0]      b1;
    } rstage_t;

    function automatic logic is_vertical(input logic signed [HEAD_W-1:0] h,
                                         input logic [ATOL_W-1:0] tol);
        logic signed [HEAD_W:0]   a;
        logic signed [HEAD_W+1:0] d;
        a = h[HEAD_W-1] ? -(HEAD_W+1)'(h) : (HEAD_W+1)'(h);
        d = (HEAD_W+2)'(a) - (HEAD_W+2)'(QUARTER_TURN);
        if (d[HEAD_W+1])
        begin
            d = -d;
        end
        return d < signed'((HEAD_W+2)'(tol));
    endfunction

    function automatic logic signed [ZW-1:0] fold_angle(input logic signed [HEAD_W-1:0] h);
        logic [HEAD_W-2:0]      f;
        logic signed [HEAD_W:0] a;
        f = h[HEAD_W-2:0] + (HEAD_W-1)'(QUARTER_TURN);
        a = signed'({2'b00, f}) - (HEAD_W+1)'(QUARTER_TURN);
        return ZW'(a) <<< ANGLE_SHIFT;
    endfunction

    function automatic logic signed [BW-1:0] scale_down(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? p + PROD_W'((64'd1 << FRACTION_BITS) - 64'd1) : p;
        adj = adj >>> FRACTION_BITS;
        return {{(BW-PROD_W){adj[PROD_W-1]}}, adj};
    endfunction

    logic [ATOL_W-1:0] angle_tol_reg;
    logic [STOL_W-1:0] slope_tol_reg;
    logic [LATENCY-1:0] vld_reg;
    logic               accept;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_tol_reg <= ATOL_W'(8);
            slope_tol_reg <= STOL_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_ANGLE_TOL: angle_tol_reg <= cfg_data[ATOL_W-1:0];
                REG_SLOPE_TOL: slope_tol_reg <= cfg_data[STOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
        end
    end

    // entry: vertical test, swap, angle fold
    cord_t cord_a [0:TANGENT_STAGES];
    cord_t cord_b [0:TANGENT_STAGES];
    side_t side_c_reg [0:TANGENT_STAGES];
    cord_t cord_a_next;
    cord_t cord_b_next;
    side_t side_next;
    cord_t cord_a0_reg;
    cord_t cord_b0_reg;

    always_comb
    begin
        logic av;
        logic bv;
        logic swap;
        av   = is_vertical(first_heading, angle_tol_reg);
        bv   = is_vertical(second_heading, angle_tol_reg);
        swap = av;
        side_next.none = av && bv;
        side_next.bv   = av || bv;
        side_next.ax   = swap ? second_x : first_x;
        side_next.ay   = swap ? second_y : first_y;
        side_next.bx   = swap ? first_x : second_x;
        side_next.by   = swap ? first_y : second_y;
        cord_a_next.cx = CORD_START;
        cord_a_next.sy = '0;
        cord_a_next.z  = fold_angle(swap ? second_heading : first_heading);
        cord_b_next.cx = CORD_START;
        cord_b_next.sy = '0;
        cord_b_next.z  = fold_angle(swap ? first_heading : second_heading);
    end

    always_ff @(posedge clk)
    begin
        cord_a0_reg   <= cord_a_next;
        cord_b0_reg   <= cord_b_next;
        side_c_reg[0] <= side_next;
    end

    assign cord_a[0] = cord_a0_reg;
    assign cord_b[0] = cord_b0_reg;

    // tangent chain
    for (genvar i = 0; i < TANGENT_STAGES; i++)
    begin : g_cordic
        rli_cordic_cell u_cell_a (
            .clk      (clk),
            .stage    (IDX_W'(i)),
            .cell_in  (cord_a[i]),
            .cell_out (cord_a[i+1])
        );
        rli_cordic_cell u_cell_b (
            .clk      (clk),
            .stage    (IDX_W'(i)),
            .cell_in  (cord_b[i]),
            .cell_out (cord_b[i+1])
        );
        always_ff @(posedge clk)
        begin
            side_c_reg[i+1] <= side_c_reg[i];
        end
    end

    // slope division setup
    div_t        sdiv_a [0:QUO_W];
    div_t        sdiv_b [0:QUO_W];
    slope_side_t sl_reg [0:QUO_W];
    div_t        sdiv_a0_reg;
    div_t        sdiv_b0_reg;
    div_t        sdiv_a_next;
    div_t        sdiv_b_next;
    slope_side_t sl_next;

    function automatic div_t slope_setup(input cord_t c, output logic cap, output logic neg);
        div_t                     r;
        logic [DIV_W-1:0]         n;
        logic [DIV_W-1:0]         dd;
        logic signed [CORD_W-1:0] mag;
        mag = c.sy[CORD_W-1] ? -c.sy : c.sy;
        n   = DIV_W'(unsigned'(mag));
        dd  = (c.cx <= 0) ? DIV_W'(1) : DIV_W'(unsigned'(c.cx));
        cap = (c.cx <= 0) || (n >= (dd << (QUO_W - FRACTION_BITS)));
        neg = c.sy[CORD_W-1];
        r.p = n << FRACTION_BITS;
        r.d = dd;
        r.q = '0;
        return r;
    endfunction

    always_comb
    begin
        sl_next.side = side_c_reg[TANGENT_STAGES];
        sdiv_a_next  = slope_setup(cord_a[TANGENT_STAGES], sl_next.a_cap, sl_next.a_neg);
        sdiv_b_next  = slope_setup(cord_b[TANGENT_STAGES], sl_next.b_cap, sl_next.b_neg);
    end

    always_ff @(posedge clk)
    begin
        sdiv_a0_reg <= sdiv_a_next;
        sdiv_b0_reg <= sdiv_b_next;
        sl_reg[0]   <= sl_next;
    end

    assign sdiv_a[0] = sdiv_a0_reg;
    assign sdiv_b[0] = sdiv_b0_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_sdiv
        rli_div_cell u_cell_a (
            .clk      (clk),
            .bit_idx  (IDX_W'(QUO_W - 1 - k)),
            .cell_in  (sdiv_a[k]),
            .cell_out (sdiv_a[k+1])
        );
        rli_div_cell u_cell_b (
            .clk      (clk),
            .bit_idx  (IDX_W'(QUO_W - 1 - k)),
            .cell_in  (sdiv_b[k]),
            .cell_out (sdiv_b[k+1])
        );
        always_ff @(posedge clk)
        begin
            sl_reg[k+1] <= sl_reg[k];
        end
    end

    // slopes
    mstage_t m_reg;
    mstage_t m_next;

    function automatic logic signed [SLOPE_W-1:0] slope_val(input logic [QUO_W-1:0] q,
                                                           input logic cap,
                                                           input logic neg);
        logic [QUO_W-1:0] mag;
        mag = (cap || q[QUO_W-1]) ? SLOPE_CAP : q;
        return neg ? -signed'(mag) : signed'(mag);
    endfunction

    always_comb
    begin
        m_next.side = sl_reg[QUO_W].side;
        m_next.m1   = slope_val(sdiv_a[QUO_W].q, sl_reg[QUO_W].a_cap, sl_reg[QUO_W].a_neg);
        m_next.m2   = slope_val(sdiv_b[QUO_W].q, sl_reg[QUO_W].b_cap, sl_reg[QUO_W].b_neg);
    end

    // products
    pstage_t p_reg;
    pstage_t p_next;

    always_comb
    begin
        p_next.side = m_reg.side;
        p_next.m1   = m_reg.m1;
        p_next.m2   = m_reg.m2;
        p_next.p1   = PROD_W'(m_reg.m1) * PROD_W'(m_reg.side.ax);
        p_next.p2   = PROD_W'(m_reg.m2) * PROD_W'(m_reg.side.bx);
    end

    // intercepts
    bstage_t b_reg;
    bstage_t b_next;

    always_comb
    begin
        b_next.bx   = p_reg.side.bx;
        b_next.bv   = p_reg.side.bv;
        b_next.none = p_reg.side.none;
        b_next.m1   = p_reg.m1;
        b_next.b1   = BW'(p_reg.side.ay) - scale_down(p_reg.p1);
        b_next.b2   = BW'(p_reg.side.by) - scale_down(p_reg.p2);
        b_next.den  = (SLOPE_W+1)'(p_reg.m1) - (SLOPE_W+1)'(p_reg.m2);
    end

    // crossing division setup
    div_t   xdiv [0:QUO_W];
    xside_t xs_reg [0:QUO_W];
    div_t   xdiv0_reg;
    div_t   xdiv_next;
    xside_t xs_next;

    always_comb
    begin
        logic signed [BW-1:0]  num;
        logic [BW-1:0]         n;
        logic [SLOPE_W:0]      dm;
        logic [DIV_W-1:0]      dd;
        logic                  par;
        num = b_reg.b2 - b_reg.b1;
        n   = num[BW-1] ? unsigned'(-num) : unsigned'(num);
        dm  = b_reg.den[SLOPE_W] ? unsigned'(-b_reg.den) : unsigned'(b_reg.den);
        par = (dm == '0) || (dm < (SLOPE_W+1)'(slope_tol_reg));
        dd  = (dm == '0) ? DIV_W'(1) : DIV_W'(dm);
        xs_next.bx   = b_reg.bx;
        xs_next.bv   = b_reg.bv;
        xs_next.none = b_reg.none || (!b_reg.bv && par);
        xs_next.neg  = num[BW-1] != b_reg.den[SLOPE_W];
        xs_next.ovf  = DIV_W'(n) >= (dd << (QUO_W - FRACTION_BITS));
        xs_next.m1   = b_reg.m1;
        xs_next.b1   = b_reg.b1;
        xdiv_next.p  = DIV_W'(n) << FRACTION_BITS;
        xdiv_next.d  = dd;
        xdiv_next.q  = '0;
    end

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        p_reg     <= p_next;
        b_reg     <= b_next;
        xdiv0_reg <= xdiv_next;
        xs_reg[0] <= xs_next;
    end

    assign xdiv[0] = xdiv0_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_xdiv
        rli_div_cell u_cell (
            .clk      (clk),
            .bit_idx  (IDX_W'(QUO_W - 1 - k)),
            .cell_in  (xdiv[k]),
            .cell_out (xdiv[k+1])
        );
        always_ff @(posedge clk)
        begin
            xs_reg[k+1] <= xs_reg[k];
        end
    end

    // x with saturation
    qstage_t q_reg;
    qstage_t q_next;

    always_comb
    begin
        logic [QUO_W:0]         qv;
        logic signed [BW-1:0]   sv;
        xside_t                 xs;
        xs = xs_reg[QUO_W];
        qv = xs.ovf ? {1'b1, {QUO_W{1'b0}}} : {1'b0, xdiv[QUO_W].q};
        sv = xs.neg ? -signed'(BW'(qv)) : signed'(BW'(qv));
        q_next.none = xs.none;
        q_next.m1   = xs.m1;
        q_next.b1   = xs.b1;
        if (xs.bv)
        begin
            q_next.x    = xs.bx;
            q_next.clip = 1'b0;
        end
        else if (sv > SAT_HI)
        begin
            q_next.x    = SAT_HI[COORD_W-1:0];
            q_next.clip = 1'b1;
        end
        else if (sv < SAT_LO)
        begin
            q_next.x    = SAT_LO[COORD_W-1:0];
            q_next.clip = 1'b1;
        end
        else
        begin
            q_next.x    = sv[COORD_W-1:0];
            q_next.clip = 1'b0;
        end
    end

    // y product
    rstage_t r_reg;
    rstage_t r_next;

    always_comb
    begin
        r_next.none = q_reg.none;
        r_next.clip = q_reg.clip;
        r_next.x    = q_reg.x;
        r_next.b1   = q_reg.b1;
        r_next.p    = PROD_W'(q_reg.m1) * PROD_W'(q_reg.x);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // y and output register
    logic signed [COORD_W-1:0] cross_x_reg;
    logic signed [COORD_W-1:0] cross_y_reg;
    logic                      no_crossing_reg;
    logic                      clipped_reg;
    logic signed [COORD_W-1:0] cross_x_next;
    logic signed [COORD_W-1:0] cross_y_next;
    logic                      no_crossing_next;
    logic                      clipped_next;

    always_comb
    begin
        logic signed [BW-1:0]      yw;
        logic signed [COORD_W-1:0] ys;
        logic                      yclip;
        yw = scale_down(r_reg.p) + r_reg.b1;
        if (yw > SAT_HI)
        begin
            ys    = SAT_HI[COORD_W-1:0];
            yclip = 1'b1;
        end
        else if (yw < SAT_LO)
        begin
            ys    = SAT_LO[COORD_W-1:0];
            yclip = 1'b1;
        end
        else
        begin
            ys    = yw[COORD_W-1:0];
            yclip = 1'b0;
        end
        no_crossing_next = r_reg.none;
        cross_x_next     = r_reg.none ? '0 : r_reg.x;
        cross_y_next     = r_reg.none ? '0 : ys;
        clipped_next     = r_reg.none ? 1'b0 : (r_reg.clip || yclip);
    end

    always_ff @(posedge clk)
    begin
        cross_x_reg     <= cross_x_next;
        cross_y_reg     <= cross_y_next;
        no_crossing_reg <= no_crossing_next;
        clipped_reg     <= clipped_next;
    end

    assign done        = vld_reg[LATENCY-1];
    assign cross_x     = cross_x_reg;
    assign cross_y     = cross_y_reg;
    assign no_crossing = no_crossing_reg;
    assign clipped     = clipped_reg;

endmodule

[hw/rtl/rli_checker.sv]
// port level checks for ray_line_intersection, bound to the top level
// depends on rli_pkg
module rli_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic signed [rli_pkg::COORD_W-1:0] cross_x,
    input logic signed [rli_pkg::COORD_W-1:0] cross_y,
    input logic                               no_crossing,
    input logic                               clipped
);
    import rli_pkg::*;

    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // every result traces back to a request
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without request");

    // every request yields a result
    a_request_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request lost");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_crossing) |-> (cross_x == '0 && cross_y == '0 && !clipped))
        else $error("no crossing result not cleared");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (cross_x == C_MAX || cross_x == C_MIN ||
                               cross_y == C_MAX || cross_y == C_MIN))
        else $error("clipped without a saturated coordinate");

endmodule

bind ray_line_intersection rli_checker u_rli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .cross_x     (cross_x),
    .cross_y     (cross_y),
    .no_crossing (no_crossing),
    .clipped     (clipped)
);

[bench/ray_line_intersection_tb.sv]
// testbench for ray_line_intersection: directed and random line pairs over several tolerance settings
// holds a bit-exact predictor of the crossing point in a small scoreboard class
// depends on rli_pkg and the ray_line_intersection rtl
`timescale 1ns / 100ps

module ray_line_intersection_tb;
    import rli_pkg::*;

    typedef struct {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [15:0] ah;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [15:0] bh;
    } line_pair_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               none;
        logic               clip;
    } crossing_t;

    localparam longint ARC [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    class crossing_board;
        longint unsigned angle_tol;
        longint unsigned slope_tol;
        crossing_t       pending[$];
        int              errors;

        function new();
            angle_tol = 8;
            slope_tol = 1;
            errors = 0;
        endfunction

        function longint unsigned magnitude(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint unsigned scaled_div(longint unsigned n, longint unsigned d);
            longint unsigned qi, r, q;
            qi = n / d;
            r = n % d;
            if (qi >= (64'd1 << (32 - FRACTION_BITS)))
                return 64'd1 << 32;
            q = qi << FRACTION_BITS;
            for (int i = FRACTION_BITS - 1; i >= 0; i--)
            begin
                r = r << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | (64'd1 << i);
                end
            end
            return q;
        endfunction

        function bit vertical(longint h);
            longint a, d;
            a = h < 0 ? -h : h;
            d = a - QUARTER_TURN;
            if (d < 0)
                d = -d;
            return longint'(d) < longint'(angle_tol);
        endfunction

        function longint slope(longint h);
            longint a, z, cx, sy, nx, ny, dv;
            longint unsigned q;
            a = ((h + 49152) & 64'h7FFF) - QUARTER_TURN;
            z = a * 65536;
            cx = 64'd1 << 30;
            sy = 0;
            for (int i = 0; i < TANGENT_STAGES && i < 24; i++)
            begin
                dv = 64'd1 << i;
                if (z >= 0)
                begin
                    nx = cx - sy / dv;
                    ny = sy + cx / dv;
                    z = z - ARC[i];
                end
                else
                begin
                    nx = cx + sy / dv;
                    ny = sy - cx / dv;
                    z = z + ARC[i];
                end
                cx = nx;
                sy = ny;
            end
            if (cx <= 0)
                q = 2147483647;
            else
            begin
                q = scaled_div(magnitude(sy), cx);
                if (q > 2147483647)
                    q = 2147483647;
            end
            return sy < 0 ? -longint'(q) : longint'(q);
        endfunction

        function longint mul_q(longint m, longint x);
            return (m * x) / (64'sd1 <<< FRACTION_BITS);
        endfunction

        function longint saturate(longint v, inout bit clip);
            if (v > 64'sd2147483647)
            begin
                clip = 1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                clip = 1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void note_request(line_pair_t r);
            longint ax, ay, ah, bx, by, bh, t, m1, m2, b1, b2, x, y, den, num, q;
            longint unsigned dm;
            bit av, bv, clip, none;
            crossing_t e;
            ax = r.ax; ay = r.ay; ah = r.ah;
            bx = r.bx; by = r.by; bh = r.bh;
            av = vertical(ah);
            bv = vertical(bh);
            clip = 0;
            none = av && bv;
            x = 0;
            y = 0;
            if (!none && av)
            begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
                t = ah; ah = bh; bh = t;
                bv = 1;
            end
            if (!none)
            begin
                m1 = slope(ah);
                b1 = ay - mul_q(m1, ax);
                if (bv)
                    x = bx;
                else
                begin
                    m2 = slope(bh);
                    den = m1 - m2;
                    dm = magnitude(den);
                    if (dm == 0 || dm < slope_tol)
                        none = 1;
                    else
                    begin
                        b2 = by - mul_q(m2, bx);
                        num = b2 - b1;
                        q = scaled_div(magnitude(num), dm);
                        if ((num < 0) != (den < 0))
                            q = -q;
                        x = saturate(q, clip);
                    end
                end
                if (!none)
                    y = saturate(mul_q(m1, x) + b1, clip);
            end
            if (none)
            begin
                x = 0;
                y = 0;
                clip = 0;
            end
            e.x = x[31:0];
            e.y = y[31:0];
            e.none = none;
            e.clip = clip;
            pending.push_back(e);
        endfunction

        function void check_result(crossing_t a);
            crossing_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result x=%h y=%h", $time, a.x, a.y);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.x !== e.x)
            begin
                $display("%0t: cross_x expected %h actual %h", $time, e.x, a.x);
                errors++;
            end
            if (a.y !== e.y)
            begin
                $display("%0t: cross_y expected %h actual %h", $time, e.y, a.y);
                errors++;
            end
            if (a.none !== e.none)
            begin
                $display("%0t: no_crossing expected %b actual %b", $time, e.none, a.none);
                errors++;
            end
            if (a.clip !== e.clip)
            begin
                $display("%0t: clipped expected %b actual %b", $time, e.clip, a.clip);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [15:0] first_heading;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [15:0] second_heading;
    logic               cfg_we;
    cfg_index_t         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               done;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic               no_crossing;
    logic               clipped;

    crossing_board board = new();
    int                idle_cycles;

    ray_line_intersection uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_x(first_x), .first_y(first_y), .first_heading(first_heading),
        .second_x(second_x), .second_y(second_y), .second_heading(second_heading),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .cross_x(cross_x), .cross_y(cross_y),
        .no_crossing(no_crossing), .clipped(clipped)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        line_pair_t r;
        crossing_t  a;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                r.ax = first_x; r.ay = first_y; r.ah = first_heading;
                r.bx = second_x; r.by = second_y; r.bh = second_heading;
                board.note_request(r);
            end
            if (done)
            begin
                a.x = cross_x; a.y = cross_y; a.none = no_crossing; a.clip = clipped;
                board.check_result(a);
            end
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= 4000)
            begin
                $display("ray_line_intersection_tb failed");
                $finish;
            end
        end
    end

    task automatic send_request(line_pair_t r);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0)
        begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        first_x <= r.ax; first_y <= r.ay; first_heading <= r.ah;
        second_x <= r.bx; second_y <= r.by; second_heading <= r.bh;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 0;
        if (idx == REG_ANGLE_TOL)
            board.angle_tol = value;
        else
            board.slope_tol = value;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) < 7)
            return $signed($urandom_range(0, 32'h07FFFFFF)) - 32'sh04000000;
        return $urandom;
    endfunction

    function automatic logic signed [15:0] rand_heading(int unsigned tol);
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 4)
            return 16'($urandom);
        if (k < 7)
            return 16'(($urandom_range(0, 1) ? 16384 : -16384)
                + $signed($urandom_range(0, 2 * tol + 4)) - $signed(tol + 2));
        if (k < 8)
            return -32768;
        return 16'($signed($urandom_range(0, 16)) - 8);
    endfunction

    function automatic line_pair_t rand_pair(int unsigned tol);
        line_pair_t r;
        r.ax = rand_coord(); r.ay = rand_coord(); r.ah = rand_heading(tol);
        r.bx = rand_coord(); r.by = rand_coord(); r.bh = rand_heading(tol);
        case ($urandom_range(0, 5))
            0: r.bh = 16'(r.ah + $signed($urandom_range(0, 6)) - 3);
            1: r.bh = r.ah + 16'sh8000;
            default: ;
        endcase
        return r;
    endfunction

    function automatic line_pair_t pair(int ax, int ay, int ah, int bx, int by, int bh);
        line_pair_t r;
        r.ax = ax; r.ay = ay; r.ah = 16'(ah);
        r.bx = bx; r.by = by; r.bh = 16'(bh);
        return r;
    endfunction

    int unsigned atol_list[5] = '{8, 0, 1024, 1, 0};
    int unsigned stol_list[5] = '{1, 0, 65536, 0, 0};

    initial
    begin
        line_pair_t directed[$];
        rst_n = 0;
        start = 0;
        cfg_we = 0;
        cfg_index = REG_ANGLE_TOL;
        cfg_data = 0;
        first_x = 0; first_y = 0; first_heading = 0;
        second_x = 0; second_y = 0; second_heading = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed.push_back(pair(0, 0, 0, 0, 0, 8192));
        directed.push_back(pair(65536, 0, 16384, 0, 65536, 0));
        directed.push_back(pair(0, 65536, 0, 131072, 0, -16384));
        directed.push_back(pair(0, 0, 16384, 65536, 0, -16384));
        directed.push_back(pair(0, 0, 100, 65536, 0, 100));
        directed.push_back(pair(0, 0, 100, 65536, 0, 101));
        directed.push_back(pair(0, 0, -32768, 0, 65536, 0));
        directed.push_back(pair(0, 0, 32767, 65536, 0, -32767));
        directed.push_back(pair(32'h7FFFFFFF, 32'h7FFFFFFF, 8192,
                                32'h80000000, 32'h80000000, -8192));
        directed.push_back(pair(32'h80000000, 32'h7FFFFFFF, 16383,
                                32'h7FFFFFFF, 32'h80000000, 0));
        directed.push_back(pair(0, 32'h7FFFFFFF, 16376, 0, 0, 0));
        directed.push_back(pair(0, 0, 16377, 32'h7FFFFFFF, 0, 16000));
        directed.push_back(pair(65536, 0, 1, 0, 32'h7FFFFFFF, 2));
        directed.push_back(pair(0, 0, 16392, 0, 0, 16391));
        directed.push_back(pair(-65536, 0, -16376, 65536, 0, 16376));
        directed.push_back(pair(12345, -6789, 4096, -4321, 98765, -4096));

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 4)
            begin
                atol_list[4] = $urandom_range(0, 1024);
                stol_list[4] = $urandom_range(0, 65536);
            end
            if (phase == 3)
                stol_list[3] = $urandom_range(0, 4096);
            write_reg(REG_ANGLE_TOL, atol_list[phase]);
            write_reg(REG_SLOPE_TOL, stol_list[phase]);
            if (phase == 0)
                foreach (directed[i])
                    send_request(directed[i]);
            for (int n = 0; n < 140; n++)
                send_request(rand_pair(atol_list[phase]));
            drain();
        end

        if (board.errors == 0)
            $display("ray_line_intersection_tb passed");
        else
            $display("ray_line_intersection_tb failed");
        $finish;
    end
endmodule
